// ===== rtl/core/iou_label_association_argmin_assert.svh =====
// Assertion macros shared by the RTL of the IoU association block.
// Each use sits on a line of its own; the clock and reset are the block's.
`ifndef IOU_LABEL_ASSOCIATION_ARGMIN_ASSERT_SVH
`define IOU_LABEL_ASSOCIATION_ARGMIN_ASSERT_SVH

// Checked only while out of reset.
`define IOU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define IOU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/iou_lbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_lbl_pkg
// Shared types and constants of the IoU label association block.
// ----------------------------------------------------------------------------
package iou_lbl_pkg;

  localparam int MAX_SLOTS_DEF  = 32;
  localparam int COORD_BITS_DEF = 12;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 5;
  localparam int LABEL_W = 8;
  localparam int COST_W  = 27;
  localparam int FRAC_W  = 16;
  localparam int QDEPTH  = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [COST_W-1:0] COST_MAX      = 27'h7FFFFFF;
  localparam logic [COST_W-1:0] LABEL_PENALTY = 27'd65536000;
  localparam logic [COST_W-1:0] THRESH_RESET  = 27'd6553600;

  localparam logic REG_THRESH = 1'b0;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_WRITE,
    CMD_QUERY
  } cmd_e;

  // Head of the command queue, as seen by the back end.
  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [LABEL_W-1:0] label;
  } q_head_t;

endpackage

// ===== rtl/core/iou_lbl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_lbl_in_if
// Command channel: op, slot, box and label with valid/ready.
// ----------------------------------------------------------------------------
interface iou_lbl_in_if #(
  parameter int COORD_BITS = iou_lbl_pkg::COORD_BITS_DEF
);
  import iou_lbl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [SLOT_W-1:0]     slot;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;
  logic [LABEL_W-1:0]    label_code;

  modport source (output valid, op, slot, box_x, box_y, box_width, box_height,
                  label_code, input ready);
  modport sink (input valid, op, slot, box_x, box_y, box_width, box_height,
                label_code, output ready);
endinterface

// ===== rtl/core/iou_lbl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_lbl_out_if
// Match result channel with valid/ready.
// ----------------------------------------------------------------------------
interface iou_lbl_out_if;
  import iou_lbl_pkg::*;

  logic              valid;
  logic              ready;
  logic              match_found;
  logic [SLOT_W-1:0] match_slot;
  logic [COST_W-1:0] match_cost;

  modport source (output valid, match_found, match_slot, match_cost, input ready);
  modport sink (input valid, match_found, match_slot, match_cost, output ready);
endinterface

// ===== rtl/core/iou_lbl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_lbl_front
// Accepts commands, decodes the op and queues them for the back end.
// ----------------------------------------------------------------------------
module iou_lbl_front #(
  parameter int COORD_BITS = iou_lbl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  iou_lbl_in_if.sink                          in_if,
  output iou_lbl_pkg::q_head_t                head_o,
  output logic [3:0][COORD_BITS-1:0]          head_box_o,
  input  logic                                pop_i
);
  import iou_lbl_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  cmd_e                        cmd_q   [QDEPTH];
  logic [SLOT_W-1:0]           slot_q  [QDEPTH];
  logic [LABEL_W-1:0]          label_q [QDEPTH];
  logic [3:0][COORD_BITS-1:0]  box_q   [QDEPTH];
  logic                        wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]               cnt_q;

  logic accept, known, push, pop;
  cmd_e dec_cmd;

  always_comb begin
    known   = 1'b1;
    dec_cmd = CMD_CLEAR;
    case (in_if.op)
      OP_CLEAR: dec_cmd = CMD_CLEAR;
      OP_WRITE: dec_cmd = CMD_WRITE;
      OP_QUERY: dec_cmd = CMD_QUERY;
      default:  known   = 1'b0;   // unused op: taken and dropped
    endcase
  end

  assign in_if.ready = (cnt_q != CW'(QDEPTH));
  assign accept      = in_if.valid && in_if.ready;
  assign push        = accept && known;
  assign pop         = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q]   <= dec_cmd;
      slot_q[wr_ptr_q]  <= in_if.slot;
      label_q[wr_ptr_q] <= in_if.label_code;
      box_q[wr_ptr_q]   <= {in_if.box_height, in_if.box_width, in_if.box_y, in_if.box_x};
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = cmd_q[rd_ptr_q];
  assign head_o.slot  = slot_q[rd_ptr_q];
  assign head_o.label = label_q[rd_ptr_q];
  assign head_box_o   = box_q[rd_ptr_q];

endmodule

// ===== rtl/core/iou_lbl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_lbl_back
// Box table, valid marks and the slot scan with a bit-serial IoU divider.
// ----------------------------------------------------------------------------
`include "iou_label_association_argmin_assert.svh"
module iou_lbl_back #(
  parameter int MAX_SLOTS  = iou_lbl_pkg::MAX_SLOTS_DEF,
  parameter int COORD_BITS = iou_lbl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iou_lbl_pkg::q_head_t                head_i,
  input  logic [3:0][COORD_BITS-1:0]          head_box_i,
  output logic                                pop_o,
  input  logic [iou_lbl_pkg::COST_W-1:0]      thr_i,
  iou_lbl_out_if.source                       out_if
);
  import iou_lbl_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int SW = COORD_BITS + 1;
  localparam int AW = 2 * SW;
  localparam int RW = AW + 1;
  localparam int QW = FRAC_W + 1;
  localparam int EW = 4 * COORD_BITS + LABEL_W;
  localparam int DIV_LAST = FRAC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_GEOM = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_COST = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [MAX_SLOTS-1:0] valid_q;
  logic [IW-1:0]        idx_q;
  logic [EW-1:0]        mem_q [MAX_SLOTS];
  logic [EW-1:0]        rd_q;

  logic [3:0][COORD_BITS-1:0] qbox_q;
  logic [LABEL_W-1:0]         qlbl_q;
  logic [SW-1:0]              iw_q, ih_q, uw_q, uh_q;
  logic                       both_emp_q, one_emp_q, ldiff_q;
  logic [AW-1:0]              inter_q, uni_q;
  logic [RW-1:0]              rem_q;
  logic [QW-1:0]              quo_q;
  logic [$clog2(DIV_LAST+1)-1:0] cnt_q;
  logic [COST_W-1:0]          best_q;
  logic [IW-1:0]              best_slot_q;
  logic                       found_q;

  logic              out_vld_q, out_found_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [COST_W-1:0] out_cost_q;

  logic is_last, wr_ok, out_free;
  assign is_last  = (idx_q == IW'(MAX_SLOTS - 1));
  assign wr_ok    = (32'(head_i.slot) < MAX_SLOTS);
  assign pop_o    = (state_q == S_IDLE) && head_i.valid;
  assign out_free = !out_vld_q || out_if.ready;

  // Table entry fields
  logic [COORD_BITS-1:0] rx, ry, rw, rh, qx, qy, qw, qh;
  logic [LABEL_W-1:0]    rl;
  assign rx = rd_q[COORD_BITS-1:0];
  assign ry = rd_q[2*COORD_BITS-1:COORD_BITS];
  assign rw = rd_q[3*COORD_BITS-1:2*COORD_BITS];
  assign rh = rd_q[4*COORD_BITS-1:3*COORD_BITS];
  assign rl = rd_q[EW-1:4*COORD_BITS];
  assign qx = qbox_q[0];
  assign qy = qbox_q[1];
  assign qw = qbox_q[2];
  assign qh = qbox_q[3];

  // Geometry of intersection and bounding rectangle
  logic [SW-1:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic [SW-1:0] ix0, ix1, iy0, iy1, ux0, ux1, uy0, uy1;
  logic          a_emp, b_emp;
  always_comb begin
    ax0 = SW'(qx);
    ax1 = SW'(qx) + SW'(qw);
    bx0 = SW'(rx);
    bx1 = SW'(rx) + SW'(rw);
    ay0 = SW'(qy);
    ay1 = SW'(qy) + SW'(qh);
    by0 = SW'(ry);
    by1 = SW'(ry) + SW'(rh);
    ix0 = (ax0 > bx0) ? ax0 : bx0;
    ix1 = (ax1 < bx1) ? ax1 : bx1;
    iy0 = (ay0 > by0) ? ay0 : by0;
    iy1 = (ay1 < by1) ? ay1 : by1;
    ux0 = (ax0 < bx0) ? ax0 : bx0;
    ux1 = (ax1 > bx1) ? ax1 : bx1;
    uy0 = (ay0 < by0) ? ay0 : by0;
    uy1 = (ay1 > by1) ? ay1 : by1;
    a_emp = (qw == '0) || (qh == '0);
    b_emp = (rw == '0) || (rh == '0);
  end

  // Divider step: quotient bit 16 first, remainder never exceeds the union
  logic [RW-1:0] div_t, rem_d;
  logic          div_ge;
  always_comb begin
    div_t  = (cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
    div_ge = (div_t >= RW'(uni_q));
    rem_d  = div_ge ? (div_t - RW'(uni_q)) : div_t;
  end

  // Cost: 100*(1-IoU) by shift-add, plus the label penalty; COST_MAX if both boxes are empty
  logic [QW-1:0]     iou, dif;
  logic [COST_W-1:0] cost100, cost;
  always_comb begin
    iou     = (one_emp_q || both_emp_q) ? '0 : quo_q;
    dif     = QW'(1 << FRAC_W) - iou;
    cost100 = (COST_W'(dif) << 6) + (COST_W'(dif) << 5) + (COST_W'(dif) << 2);
    if (both_emp_q) cost = COST_MAX;
    else            cost = cost100 + (ldiff_q ? LABEL_PENALTY : '0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (head_i.valid && head_i.cmd == CMD_QUERY) state_d = S_SCAN;
      S_SCAN: begin
        if (valid_q[idx_q]) state_d = S_GEOM;
        else if (is_last)   state_d = S_OUT;
      end
      S_GEOM: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = (both_emp_q || one_emp_q) ? S_COST : S_DIV;
      S_DIV:  if (cnt_q == $bits(cnt_q)'(DIV_LAST)) state_d = S_COST;
      S_COST: state_d = is_last ? S_OUT : S_SCAN;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && head_i.cmd == CMD_CLEAR) valid_q <= '0;
      if (pop_o && head_i.cmd == CMD_WRITE && wr_ok) valid_q[IW'(head_i.slot)] <= 1'b1;
      if (state_q == S_OUT && out_free) out_vld_q <= 1'b1;
      else if (out_if.ready)            out_vld_q <= 1'b0;
    end
  end

  // Table memory, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.cmd == CMD_WRITE && wr_ok) begin
      mem_q[IW'(head_i.slot)] <= {head_i.label, head_box_i};
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        qbox_q  <= head_box_i;
        qlbl_q  <= head_i.label;
        idx_q   <= '0;
        best_q  <= thr_i;
        found_q <= 1'b0;
        best_slot_q <= '0;
      end
      S_SCAN: if (!valid_q[idx_q] && !is_last) idx_q <= idx_q + 1'b1;
      S_GEOM: begin
        iw_q <= (ix1 > ix0) ? (ix1 - ix0) : '0;
        ih_q <= (iy1 > iy0) ? (iy1 - iy0) : '0;
        uw_q <= ux1 - ux0;
        uh_q <= uy1 - uy0;
        both_emp_q <= a_emp && b_emp;
        one_emp_q  <= a_emp ^ b_emp;
        ldiff_q    <= (qlbl_q != rl);
      end
      S_MUL1: inter_q <= iw_q * ih_q;
      S_MUL2: begin
        uni_q <= uw_q * uh_q;
        rem_q <= RW'(inter_q);
        quo_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[QW-2:0], div_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      S_COST: begin
        if (cost < best_q) begin
          best_q      <= cost;
          best_slot_q <= idx_q;
          found_q     <= 1'b1;
        end
        if (!is_last) idx_q <= idx_q + 1'b1;
      end
      S_OUT: if (out_free) begin
        out_found_q <= found_q;
        out_slot_q  <= SLOT_W'(best_slot_q);
        out_cost_q  <= best_q;
      end
      default: ;
    endcase
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.match_found = out_found_q;
  assign out_if.match_slot  = out_slot_q;
  assign out_if.match_cost  = out_cost_q;

  `IOU_ASSERT(a_div_cnt, (state_q == S_DIV) |-> (cnt_q <= $bits(cnt_q)'(DIV_LAST)), "divider ran past its last step")
  `IOU_ASSERT(a_iou_le_one, (state_q == S_COST && !one_emp_q && !both_emp_q) |-> (quo_q <= QW'(1 << FRAC_W)), "IoU above one")
  `IOU_ASSERT(a_out_from_done, $rose(out_vld_q) |-> $past(state_q == S_OUT), "result raised outside scan end")
  `IOU_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == S_IDLE && !out_vld_q), "not idle in reset")

endmodule

// ===== rtl/core/iou_label_association_argmin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_label_association_argmin
// IoU/label cost association against a table of known boxes, lowest slot wins.
// ----------------------------------------------------------------------------
// Clear and write are done by the back end as it pops them from the queue.
// A query scans every slot of the table; each valid slot costs a table read,
// geometry, two multiplies, 17 serial divide steps and a compare; an empty
// box skips the divide steps.
// Reset clears all valid marks, sets the threshold to 100.0; table contents
// stay undefined until written.
module iou_label_association_argmin #(
  parameter int MAX_SLOTS  = iou_lbl_pkg::MAX_SLOTS_DEF,
  parameter int COORD_BITS = iou_lbl_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  iou_lbl_in_if.sink                   req_i,
  iou_lbl_out_if.source                rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import iou_lbl_pkg::*;

  logic [COST_W-1:0]          thr_q;
  q_head_t                    head;
  logic [3:0][COORD_BITS-1:0] head_box;
  logic                       pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESH) ? {{(32 - COST_W){1'b0}}, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_THRESH) begin
      thr_q <= pwdata[COST_W-1:0];
    end
  end

  iou_lbl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_i),
    .head_o     (head),
    .head_box_o (head_box),
    .pop_i      (pop)
  );

  iou_lbl_back #(.MAX_SLOTS(MAX_SLOTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_box_i (head_box),
    .pop_o      (pop),
    .thr_i      (thr_q),
    .out_if     (rsp_o)
  );

endmodule
